### sv/tpt_pkg.sv
// Shared types and constants for the TCP port table.
package tpt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32768;
    localparam int PORT_W      = 16;
    localparam int INDEX_W     = 15;
    localparam int WORD_BITS   = 32;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int NUM_WORDS   = (TABLE_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int VISIT_W     = $clog2(NUM_WORDS + 1);
    localparam int LAST_WORD   = NUM_WORDS - 1;
    localparam int LAST_BITS   = TABLE_DEPTH - LAST_WORD * WORD_BITS;

    // Valid bits of the last table word
    localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

    // Port number constants
    localparam logic [PORT_W-1:0] HIGH_BASE  = 16'h8000;
    localparam logic [PORT_W-1:0] INDEX_MASK = 16'h7FFF;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_QUERY    = 2'd0,
        KIND_OPEN     = 2'd1,
        KIND_GET_FREE = 2'd2,
        KIND_RELEASE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_NOFREE = 2'd2
    } t_status;

    // Classified request
    typedef struct packed {
        t_kind              kind;
        logic               high;
        logic               range_err;
        logic [INDEX_W-1:0] idx;
    } t_cmd;

endpackage

### sv/tcp_port_table_unit.sv
// Top level of the TCP port table: front stage, command queue and table engine.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------------
//  request   | i_push / o_full         | i_kind[1:0], i_port[15:0]
//  result    | o_empty / i_pop         | o_port_open, o_status[1:0], o_granted_port[15:0]
//
// The front stage registers each command and the queue stores it; the table engine then reads
// the table word for query, open and release, and answers a port outside its range without a read.
// Get free reads the used table one 32-bit word at a time through its single read port,
// at most NUM_WORDS + 1 words (1025 at full depth).
// After reset a clearing pass writes both tables, one word per cycle;
// requests are taken into the queue meanwhile but not executed.
// A waiting result stalls the table engine, which starts the next command the cycle after
// the result is taken; the front stage and queue keep accepting until they fill.
module tcp_port_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [1:0]                  i_kind,
    input  logic [tpt_pkg::PORT_W-1:0]  i_port,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic                        o_port_open,
    output logic [1:0]                  o_status,
    output logic [tpt_pkg::PORT_W-1:0]  o_granted_port
);

    tpt_pkg::t_cmd front_cmd;
    tpt_pkg::t_cmd queue_cmd;
    logic          front_valid;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          q_push;

    assign q_push = front_valid && !q_full;

    tpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_kind      (i_kind),
        .i_port      (i_port),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (!q_full)
    );

    tpt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (queue_cmd)
    );

    tpt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (queue_cmd),
        .i_cmd_valid    (!q_empty),
        .o_cmd_pop      (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_port_open    (o_port_open),
        .o_status       (o_status),
        .o_granted_port (o_granted_port)
    );

    // Engine only takes commands that exist
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // A held front command must stay put while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && q_full) |=> (front_valid && $stable(front_cmd)))
        else $error("front command lost while queue full");

    // A granted port is always a successful high port with no open flag
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_granted_port != '0) |->
        (o_status == tpt_pkg::STATUS_OK && !o_port_open && o_granted_port[15]))
        else $error("granted port with bad status");

    // An open port is only reported with ok status
    a_open_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_port_open) |-> (o_status == tpt_pkg::STATUS_OK))
        else $error("port_open set with error status");

endmodule

### sv/tpt_front.sv
// Front stage: accepts requests, checks port ranges and registers the command.
module tpt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [1:0]                  i_kind,
    input  logic [tpt_pkg::PORT_W-1:0]  i_port,
    output tpt_pkg::t_cmd               o_cmd,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready
);

    logic          r_valid;
    tpt_pkg::t_cmd r_cmd;
    tpt_pkg::t_cmd n_cmd;
    logic          accept;
    logic          in_table;
    logic          high;

    assign o_full   = r_valid && !i_cmd_ready;
    assign accept   = i_push && !o_full;

    // Classify the incoming request
    always_comb begin
        n_cmd.kind = tpt_pkg::t_kind'(i_kind);
        n_cmd.idx  = tpt_pkg::INDEX_W'(i_port & tpt_pkg::INDEX_MASK);
        high       = (i_port & tpt_pkg::HIGH_BASE) != '0;
        n_cmd.high = high;
        in_table   = 32'(n_cmd.idx) < tpt_pkg::TABLE_DEPTH;
        case (n_cmd.kind)
            tpt_pkg::KIND_QUERY:    n_cmd.range_err = !in_table;
            tpt_pkg::KIND_OPEN:     n_cmd.range_err = high || !in_table;
            tpt_pkg::KIND_GET_FREE: n_cmd.range_err = 1'b0;
            tpt_pkg::KIND_RELEASE:  n_cmd.range_err = !high || !in_table;
            default:                n_cmd.range_err = 1'b1;
        endcase
    end

    // Command holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

endmodule

### sv/tpt_cmd_queue.sv
// Small command queue that decouples the front stage from the table engine.
module tpt_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tpt_pkg::t_cmd o_cmd
);

    tpt_pkg::t_cmd                r_mem [tpt_pkg::QUEUE_DEPTH];
    logic [tpt_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [tpt_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [tpt_pkg::QUEUE_AW:0]   r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = r_count == (tpt_pkg::QUEUE_AW + 1)'(tpt_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### sv/tpt_back.sv
// Table engine: clears, reads and updates the listen and used tables, scans for free ports.
module tpt_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tpt_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic                        o_port_open,
    output logic [1:0]                  o_status,
    output logic [tpt_pkg::PORT_W-1:0]  o_granted_port
);

    localparam int WB = tpt_pkg::WORD_BITS;
    localparam int AW = tpt_pkg::WORD_AW;
    localparam int OW = tpt_pkg::OFF_W;
    localparam int IW = tpt_pkg::INDEX_W;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_ACCESS = 4'b0100,
        S_SCAN   = 4'b1000
    } t_state;

    typedef struct packed {
        logic          found;
        logic [OW-1:0] off;
    } t_find;

    // Lowest set bit of a word
    function automatic t_find find_first(input logic [WB-1:0] v);
        t_find res;
        res.found = 1'b0;
        res.off   = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (v[i]) begin
                res.found = 1'b1;
                res.off   = OW'(i);
            end
        end
        return res;
    endfunction

    // Table memories, one bit per port, WB bits per word
    logic [WB-1:0] r_listen_mem [tpt_pkg::NUM_WORDS];
    logic [WB-1:0] r_used_mem   [tpt_pkg::NUM_WORDS];
    logic [WB-1:0] r_listen_q;
    logic [WB-1:0] r_used_q;

    logic [AW-1:0] mem_ra;
    logic [AW-1:0] mem_wa;
    logic          we_listen;
    logic          we_used;
    logic [WB-1:0] wd_listen;
    logic [WB-1:0] wd_used;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_clr_addr, n_clr_addr;
    tpt_pkg::t_cmd                 r_cmd, n_cmd;
    logic [IW-1:0]                 r_scan_ptr, n_scan_ptr;
    logic [AW-1:0]                 r_rd_word, n_rd_word;
    logic [tpt_pkg::VISIT_W-1:0]   r_visit, n_visit;
    logic [OW-1:0]                 r_start_off, n_start_off;
    logic                          r_res_valid, n_res_valid;
    logic                          r_res_open, n_res_open;
    tpt_pkg::t_status              r_res_status, n_res_status;
    logic [tpt_pkg::PORT_W-1:0]    r_res_granted, n_res_granted;

    logic [WB-1:0] scan_mask;
    logic [WB-1:0] free_vec;
    t_find         hit;
    logic [IW-1:0] hit_idx;
    logic [AW-1:0] next_word;
    logic [OW-1:0] cmd_off;
    logic [WB-1:0] cmd_bit;

    // Scan window: skip entries below the start on the first word, and past the table end
    always_comb begin
        scan_mask = (r_visit == '0) ? ({WB{1'b1}} << r_start_off) : {WB{1'b1}};
        if (r_rd_word == AW'(tpt_pkg::LAST_WORD)) begin
            scan_mask = scan_mask & tpt_pkg::LAST_MASK;
        end
        free_vec  = ~r_used_q & scan_mask;
        hit       = find_first(free_vec);
        hit_idx   = IW'({r_rd_word, hit.off});
        next_word = (r_rd_word == AW'(tpt_pkg::LAST_WORD)) ? '0 : r_rd_word + 1'b1;
        cmd_off   = r_cmd.idx[OW-1:0];
        cmd_bit   = {{(WB-1){1'b0}}, 1'b1} << cmd_off;
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_cmd         = r_cmd;
        n_scan_ptr    = r_scan_ptr;
        n_rd_word     = r_rd_word;
        n_visit       = r_visit;
        n_start_off   = r_start_off;
        n_res_valid   = r_res_valid;
        n_res_open    = r_res_open;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        o_cmd_pop     = 1'b0;
        mem_ra        = i_cmd.idx[OW +: AW];
        mem_wa        = r_clr_addr;
        we_listen     = 1'b0;
        we_used       = 1'b0;
        wd_listen     = '0;
        wd_used       = '0;

        if (i_pop && r_res_valid) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                we_listen = 1'b1;
                we_used   = 1'b1;
                if (r_clr_addr == AW'(tpt_pkg::LAST_WORD)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.range_err) begin
                        n_res_valid   = 1'b1;
                        n_res_open    = 1'b0;
                        n_res_status  = tpt_pkg::STATUS_RANGE;
                        n_res_granted = '0;
                    end else if (i_cmd.kind == tpt_pkg::KIND_GET_FREE) begin
                        mem_ra      = r_scan_ptr[OW +: AW];
                        n_rd_word   = r_scan_ptr[OW +: AW];
                        n_start_off = r_scan_ptr[OW-1:0];
                        n_visit     = '0;
                        n_state     = S_SCAN;
                    end else begin
                        n_state = S_ACCESS;
                    end
                end
            end
            S_ACCESS: begin
                mem_wa        = r_cmd.idx[OW +: AW];
                n_res_valid   = 1'b1;
                n_res_open    = 1'b0;
                n_res_status  = tpt_pkg::STATUS_OK;
                n_res_granted = '0;
                n_state       = S_IDLE;
                case (r_cmd.kind)
                    tpt_pkg::KIND_QUERY: begin
                        n_res_open = r_cmd.high ? r_used_q[cmd_off] : r_listen_q[cmd_off];
                    end
                    tpt_pkg::KIND_OPEN: begin
                        we_listen = 1'b1;
                        wd_listen = r_listen_q | cmd_bit;
                    end
                    tpt_pkg::KIND_RELEASE: begin
                        we_used = 1'b1;
                        wd_used = r_used_q & ~cmd_bit;
                    end
                    default: begin
                        n_res_open = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                mem_wa = r_rd_word;
                if (hit.found) begin
                    we_used       = 1'b1;
                    wd_used       = r_used_q | ({{(WB-1){1'b0}}, 1'b1} << hit.off);
                    n_scan_ptr    = (hit_idx == IW'(tpt_pkg::TABLE_DEPTH - 1)) ?
                                    '0 : hit_idx + 1'b1;
                    n_res_valid   = 1'b1;
                    n_res_open    = 1'b0;
                    n_res_status  = tpt_pkg::STATUS_OK;
                    n_res_granted = tpt_pkg::HIGH_BASE | tpt_pkg::PORT_W'(hit_idx);
                    n_state       = S_IDLE;
                end else if (r_visit == tpt_pkg::VISIT_W'(tpt_pkg::NUM_WORDS)) begin
                    n_res_valid   = 1'b1;
                    n_res_open    = 1'b0;
                    n_res_status  = tpt_pkg::STATUS_NOFREE;
                    n_res_granted = '0;
                    n_state       = S_IDLE;
                end else begin
                    mem_ra    = next_word;
                    n_rd_word = next_word;
                    n_visit   = r_visit + 1'b1;
                end
            end
            default: begin
                n_state    = S_CLEAR;
                n_clr_addr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_scan_ptr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_scan_ptr  <= n_scan_ptr;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_rd_word     <= n_rd_word;
        r_visit       <= n_visit;
        r_start_off   <= n_start_off;
        r_res_open    <= n_res_open;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
    end

    // Table memories with registered read
    always_ff @(posedge i_clk) begin
        if (we_listen) begin
            r_listen_mem[mem_wa] <= wd_listen;
        end
        if (we_used) begin
            r_used_mem[mem_wa] <= wd_used;
        end
        r_listen_q <= r_listen_mem[mem_ra];
        r_used_q   <= r_used_mem[mem_ra];
    end

    assign o_empty        = !r_res_valid;
    assign o_port_open    = r_res_open;
    assign o_status       = r_res_status;
    assign o_granted_port = r_res_granted;

endmodule

### sim/tb_tcp_port_table_unit.sv
// Testbench for tcp_port_table_unit: random and directed port requests checked against a predictor.
`timescale 1ns / 1ps

module tb_tcp_port_table_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 50;

    typedef struct {
        tpt_pkg::t_kind             kind;
        logic [tpt_pkg::PORT_W-1:0] port;
    } t_port_req;

    typedef struct {
        logic                       port_open;
        tpt_pkg::t_status           status;
        logic [tpt_pkg::PORT_W-1:0] granted;
    } t_port_reply;

    // DUT ports
    logic                       i_clk;
    logic                       i_rst_n   = 1'b0;
    logic                       i_push    = 1'b0;
    logic [1:0]                 i_kind    = tpt_pkg::KIND_QUERY;
    logic [tpt_pkg::PORT_W-1:0] i_port    = '0;
    logic                       i_pop     = 1'b0;
    logic                       o_full;
    logic                       o_empty;
    logic                       o_port_open;
    logic [1:0]                 o_status;
    logic [tpt_pkg::PORT_W-1:0] o_granted_port;

    // Shadow copy of the tables
    bit listen_map [tpt_pkg::TABLE_DEPTH];
    bit used_map   [tpt_pkg::TABLE_DEPTH];
    int next_scan = 0;

    t_port_req   pending_reqs [$];
    t_port_reply reply_q [$];
    t_port_reply oldest_reply;
    t_port_req   drive_req;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;
    int gen_gets       = 0;

    tcp_port_table_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_kind         (i_kind),
        .i_port         (i_port),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_port_open    (o_port_open),
        .o_status       (o_status),
        .o_granted_port (o_granted_port)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Table behavior: updates the shadow state, returns the reply for one request
    function automatic t_port_reply port_table_reply(t_port_req req);
        t_port_reply r;
        int idx;
        int p;
        logic hi;
        r.port_open = 1'b0;
        r.status    = tpt_pkg::STATUS_OK;
        r.granted   = '0;
        idx = int'(req.port[tpt_pkg::INDEX_W-1:0]);
        hi  = req.port[tpt_pkg::PORT_W-1];
        case (req.kind)
            tpt_pkg::KIND_QUERY: begin
                if (idx >= tpt_pkg::TABLE_DEPTH)
                    r.status = tpt_pkg::STATUS_RANGE;
                else
                    r.port_open = hi ? used_map[idx] : listen_map[idx];
            end
            tpt_pkg::KIND_OPEN: begin
                if (hi || idx >= tpt_pkg::TABLE_DEPTH)
                    r.status = tpt_pkg::STATUS_RANGE;
                else
                    listen_map[idx] = 1'b1;
            end
            tpt_pkg::KIND_GET_FREE: begin
                p = (next_scan >= tpt_pkg::TABLE_DEPTH) ? 0 : next_scan;
                r.status = tpt_pkg::STATUS_NOFREE;
                for (int n = 0; n < tpt_pkg::TABLE_DEPTH; n++) begin
                    if (!used_map[p]) begin
                        used_map[p] = 1'b1;
                        next_scan   = (p + 1 >= tpt_pkg::TABLE_DEPTH) ? 0 : p + 1;
                        r.status    = tpt_pkg::STATUS_OK;
                        r.granted   = tpt_pkg::HIGH_BASE + tpt_pkg::PORT_W'(p);
                        break;
                    end
                    p = (p + 1 >= tpt_pkg::TABLE_DEPTH) ? 0 : p + 1;
                end
            end
            default: begin
                if (!hi || idx >= tpt_pkg::TABLE_DEPTH)
                    r.status = tpt_pkg::STATUS_RANGE;
                else
                    used_map[idx] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        $error("%s", msg);
    endtask

    task automatic check_field(input string field, input logic [tpt_pkg::PORT_W-1:0] want,
                               input logic [tpt_pkg::PORT_W-1:0] got);
        if (want !== got)
            note_failure($sformatf("%s: expected 0x%0h, got 0x%0h", field, want, got));
    endtask

    task automatic queue_req(input tpt_pkg::t_kind kind,
                             input logic [tpt_pkg::PORT_W-1:0] port);
        t_port_req req;
        req.kind = kind;
        req.port = port;
        pending_reqs.push_back(req);
    endtask

    // Mostly well-formed traffic: low ports from a hot set, high ports near recent grants
    task automatic queue_random_req();
        tpt_pkg::t_kind kind;
        logic [tpt_pkg::PORT_W-1:0] port;
        int pick;
        int sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (pick < 35)
            kind = tpt_pkg::KIND_QUERY;
        else if (pick < 55)
            kind = tpt_pkg::KIND_OPEN;
        else if (pick < 80)
            kind = tpt_pkg::KIND_GET_FREE;
        else
            kind = tpt_pkg::KIND_RELEASE;

        if (sel < 20)
            port = tpt_pkg::PORT_W'($urandom_range(0, 16'hFFFF));
        else if (kind == tpt_pkg::KIND_RELEASE || (kind == tpt_pkg::KIND_QUERY && sel < 55))
            port = tpt_pkg::HIGH_BASE + tpt_pkg::PORT_W'($urandom_range(0, gen_gets + 8));
        else if (sel < 60)
            port = tpt_pkg::PORT_W'($urandom_range(0, 31));
        else if (sel < 75)
            port = tpt_pkg::INDEX_MASK - tpt_pkg::PORT_W'($urandom_range(0, 31));
        else if (sel < 90)
            port = tpt_pkg::PORT_W'($urandom_range(0, 16'h7FFF));
        else
            port = tpt_pkg::HIGH_BASE + tpt_pkg::PORT_W'($urandom_range(0, 16'h7FFF));

        if (kind == tpt_pkg::KIND_GET_FREE)
            gen_gets++;
        queue_req(kind, port);
    endtask

    // Wait until every request is sent and every reply has come back
    task automatic drain_all();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_reqs.size() != 0 || i_push || reply_q.size() != 0);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full)
                reply_q.push_back(port_table_reply('{tpt_pkg::t_kind'(i_kind), i_port}));
            if (!i_push || !o_full) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drive_req = pending_reqs.pop_front();
                    i_push <= 1'b1;
                    i_kind <= drive_req.kind;
                    i_port <= drive_req.port;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // Reply monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (reply_q.size() == 0) begin
                    note_failure("reply transaction with no request outstanding");
                end else begin
                    oldest_reply = reply_q.pop_front();
                    check_field("port_open", oldest_reply.port_open, o_port_open);
                    check_field("status", oldest_reply.status, o_status);
                    check_field("granted_port", oldest_reply.granted, o_granted_port);
                end
            end
            i_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL tcp_port_table_unit");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range edges, range errors, grant order, release and re-query
        queue_req(tpt_pkg::KIND_QUERY,    16'h0000);
        queue_req(tpt_pkg::KIND_OPEN,     16'h0000);
        queue_req(tpt_pkg::KIND_QUERY,    16'h0000);
        queue_req(tpt_pkg::KIND_OPEN,     16'h7FFF);
        queue_req(tpt_pkg::KIND_QUERY,    16'h7FFF);
        queue_req(tpt_pkg::KIND_OPEN,     16'h8000);
        queue_req(tpt_pkg::KIND_OPEN,     16'hFFFF);
        queue_req(tpt_pkg::KIND_RELEASE,  16'h0000);
        queue_req(tpt_pkg::KIND_RELEASE,  16'h7FFF);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'h0000);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'hFFFF);
        queue_req(tpt_pkg::KIND_QUERY,    16'h8000);
        queue_req(tpt_pkg::KIND_QUERY,    16'hFFFF);
        queue_req(tpt_pkg::KIND_RELEASE,  16'h8000);
        queue_req(tpt_pkg::KIND_QUERY,    16'h8000);
        queue_req(tpt_pkg::KIND_RELEASE,  16'hFFFF);
        queue_req(tpt_pkg::KIND_QUERY,    16'h8001);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'h1234);
        queue_req(tpt_pkg::KIND_OPEN,     16'h5555);
        queue_req(tpt_pkg::KIND_QUERY,    16'h5555);
        queue_req(tpt_pkg::KIND_QUERY,    16'hAAAA);
        queue_req(tpt_pkg::KIND_QUERY,    16'h2AAA);
        gen_gets = 3;
        drain_all();

        // Random traffic under four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 11 : 0;
            recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 11 : 0;
            repeat (100) queue_random_req();
            drain_all();
        end

        // Directed tail: releases and re-grants around the scan pointer
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_req(tpt_pkg::KIND_GET_FREE, 16'h0000);
        queue_req(tpt_pkg::KIND_QUERY,    16'hC000);
        queue_req(tpt_pkg::KIND_RELEASE,  16'hB039);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'hFFFF);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'h0000);
        queue_req(tpt_pkg::KIND_RELEASE,  16'hFFFF);
        queue_req(tpt_pkg::KIND_QUERY,    16'hFFFF);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'h0000);
        queue_req(tpt_pkg::KIND_QUERY,    16'hFFFF);
        queue_req(tpt_pkg::KIND_RELEASE,  16'h8000);
        queue_req(tpt_pkg::KIND_GET_FREE, 16'h0000);
        drain_all();

        // Catch any stray replies
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS tcp_port_table_unit");
        else
            $display("FAIL tcp_port_table_unit");
        $finish;
    end

endmodule

### tcp_port_table_unit.f
sv/tpt_pkg.sv
sv/tpt_front.sv
sv/tpt_cmd_queue.sv
sv/tpt_back.sv
sv/tcp_port_table_unit.sv
sim/tb_tcp_port_table_unit.sv
